// ===== rtl/core/rwb_pkg.sv =====
`default_nettype none
package rwb_pkg;

    typedef enum logic [1:0] {
        REQ_ADD  = 2'd0,
        REQ_PEEK = 2'd1,
        REQ_POP  = 2'd2,
        REQ_ADV  = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        STS_OK            = 2'd0,
        STS_OCCUPIED      = 2'd1,
        STS_OUT_OF_WINDOW = 2'd2,
        STS_EMPTY         = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_PEEK,
        S_PEEK_RD,
        S_POP,
        S_ADV_INIT,
        S_ADV,
        S_ADV_END
    } t_state;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  seqnum;
        logic [9:0]  seg_length;
        logic [31:0] timestamp;
        logic [7:0]  expected_seqnum;
        logic [7:0]  new_expected;
    } t_rwb_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  slot_index;
        logic [7:0]  out_seqnum;
        logic [9:0]  out_length;
        logic [31:0] out_timestamp;
        logic        is_empty_flag;
    } t_rwb_out;

    typedef struct packed {
        logic [7:0]  seqnum;
        logic [9:0]  length;
        logic [31:0] timestamp;
    } t_slot_entry;

endpackage
`default_nettype wire

// ===== rtl/core/reorder_window_buffer_unit.sv =====
`default_nettype none
// Receive-side reorder window over 8-bit sequence numbers. Pulse start while busy is low to
// issue one request (add, peek, pop or advance); exactly one result follows on o_rsp, marked
// by o_done for a single cycle, and must be captured then since it cannot be held off. The
// slot store is a single-port-read memory walked one slot per cycle by a small sequencer that
// shares one 8-bit subtractor for slot offsets, window shift and move targets. Add and pop
// need no scan, a peek lasts longer the farther it scans from the read pointer, and an
// advance lasts longest, since it visits every slot
// and copies survivors down through the memory's one read and one write port.
module reorder_window_buffer_unit #(
    parameter int WINDOW = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    input  rwb_pkg::t_rwb_in    i_req,
    output logic                busy,
    output logic                o_done,
    output rwb_pkg::t_rwb_out   o_rsp
);

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW - 1);

    rwb_pkg::t_state   r_state, n_state;
    logic [WINDOW-1:0] r_valid, n_valid;
    logic [CW-1:0]     r_count, n_count;
    logic [IW-1:0]     r_ptr, n_ptr;
    logic [IW-1:0]     r_idx, n_idx;
    logic [7:0]        r_sh, n_sh;
    logic              r_cp_pend, n_cp_pend;
    logic [IW-1:0]     r_cp_dst, n_cp_dst;
    rwb_pkg::t_rwb_in  r_req, n_req;
    logic              r_done, n_done;
    rwb_pkg::t_rwb_out r_rsp, n_rsp;

    logic                 mem_we;
    logic [IW-1:0]        mem_waddr;
    logic [IW-1:0]        mem_raddr;
    rwb_pkg::t_slot_entry mem_wdata;
    rwb_pkg::t_slot_entry mem_rdata;

    logic [7:0] alu_a, alu_b, alu_diff;
    logic       alu_borrow;

    logic              emit;
    rwb_pkg::t_rwb_out rsp;

    rwb_slot_mem #(
        .DEPTH (WINDOW),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rwb_off_unit u_off (
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_diff   (alu_diff),
        .o_borrow (alu_borrow)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rwb_pkg::S_IDLE;
            r_valid   <= '0;
            r_count   <= '0;
            r_ptr     <= '0;
            r_cp_pend <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_count   <= n_count;
            r_ptr     <= n_ptr;
            r_cp_pend <= n_cp_pend;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_sh     <= n_sh;
        r_cp_dst <= n_cp_dst;
        r_req    <= n_req;
        r_rsp    <= n_rsp;
    end

    always_comb begin
        n_state   = r_state;
        n_valid   = r_valid;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_idx     = r_idx;
        n_sh      = r_sh;
        n_cp_pend = 1'b0;
        n_cp_dst  = r_cp_dst;
        n_req     = r_req;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        mem_we    = 1'b0;
        mem_waddr = r_cp_dst;
        mem_wdata = mem_rdata;
        mem_raddr = r_idx;
        alu_a     = r_req.seqnum;
        alu_b     = r_req.expected_seqnum;
        emit      = 1'b0;
        rsp       = '0;

        unique case (r_state)
            rwb_pkg::S_IDLE: begin
                if (start) begin
                    n_req = i_req;
                    unique case (i_req.req_type)
                        rwb_pkg::REQ_ADD:  n_state = rwb_pkg::S_ADD;
                        rwb_pkg::REQ_PEEK: begin
                            n_idx   = r_ptr;
                            n_state = rwb_pkg::S_PEEK;
                        end
                        rwb_pkg::REQ_POP:  n_state = rwb_pkg::S_POP;
                        default:           n_state = rwb_pkg::S_ADV_INIT;
                    endcase
                end
            end

            rwb_pkg::S_ADD: begin
                emit    = 1'b1;
                n_state = rwb_pkg::S_IDLE;
                if ({1'b0, alu_diff} >= 9'(WINDOW)) begin
                    rsp.status = rwb_pkg::STS_OUT_OF_WINDOW;
                end else if (r_valid[alu_diff[IW-1:0]]) begin
                    rsp.status = rwb_pkg::STS_OCCUPIED;
                end else begin
                    mem_we                      = 1'b1;
                    mem_waddr                   = alu_diff[IW-1:0];
                    mem_wdata.seqnum            = r_req.seqnum;
                    mem_wdata.length            = r_req.seg_length;
                    mem_wdata.timestamp         = r_req.timestamp;
                    n_valid[alu_diff[IW-1:0]]   = 1'b1;
                    n_count                     = r_count + 1'b1;
                    rsp.status                  = rwb_pkg::STS_OK;
                    rsp.slot_index              = 5'(alu_diff[IW-1:0]);
                end
            end

            rwb_pkg::S_PEEK: begin
                if (r_count == '0) begin
                    emit       = 1'b1;
                    rsp.status = rwb_pkg::STS_EMPTY;
                    n_state    = rwb_pkg::S_IDLE;
                end else if (r_valid[r_idx]) begin
                    // read issued at r_idx this cycle, data lands next cycle
                    n_ptr   = r_idx;
                    n_state = rwb_pkg::S_PEEK_RD;
                end else if (r_idx == LAST_IDX) begin
                    emit       = 1'b1;
                    rsp.status = rwb_pkg::STS_EMPTY;
                    n_state    = rwb_pkg::S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            rwb_pkg::S_PEEK_RD: begin
                emit              = 1'b1;
                rsp.status        = rwb_pkg::STS_OK;
                rsp.slot_index    = 5'(r_idx);
                rsp.out_seqnum    = mem_rdata.seqnum;
                rsp.out_length    = mem_rdata.length;
                rsp.out_timestamp = mem_rdata.timestamp;
                n_state           = rwb_pkg::S_IDLE;
            end

            rwb_pkg::S_POP: begin
                emit    = 1'b1;
                n_state = rwb_pkg::S_IDLE;
                if (r_valid[r_ptr]) begin
                    n_valid[r_ptr] = 1'b0;
                    n_count        = r_count - 1'b1;
                    rsp.status     = rwb_pkg::STS_OK;
                    rsp.slot_index = 5'(r_ptr);
                end else begin
                    rsp.status = rwb_pkg::STS_EMPTY;
                end
            end

            rwb_pkg::S_ADV_INIT: begin
                alu_a   = r_req.new_expected;
                n_sh    = alu_diff;
                n_idx   = '0;
                n_state = rwb_pkg::S_ADV;
            end

            rwb_pkg::S_ADV: begin
                alu_a = 8'(r_idx);
                alu_b = r_sh;
                // finish the copy whose source was read last cycle
                if (r_cp_pend) begin
                    mem_we = 1'b1;
                end
                if (r_valid[r_idx]) begin
                    n_valid[r_idx] = 1'b0;
                    if (!alu_borrow) begin
                        n_valid[alu_diff[IW-1:0]] = 1'b1;
                        n_cp_pend                 = 1'b1;
                        n_cp_dst                  = alu_diff[IW-1:0];
                    end else begin
                        n_count = r_count - 1'b1;
                    end
                end
                if (r_idx == LAST_IDX) begin
                    n_state = rwb_pkg::S_ADV_END;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            rwb_pkg::S_ADV_END: begin
                if (r_cp_pend) begin
                    mem_we = 1'b1;
                end
                n_ptr      = '0;
                emit       = 1'b1;
                rsp.status = rwb_pkg::STS_OK;
                n_state    = rwb_pkg::S_IDLE;
            end

            default: begin
                n_state = rwb_pkg::S_IDLE;
            end
        endcase

        if (emit) begin
            n_done              = 1'b1;
            n_rsp               = rsp;
            n_rsp.is_empty_flag = (n_count == '0);
        end
    end

    assign busy   = (r_state != rwb_pkg::S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule
`default_nettype wire

// ===== rtl/core/rwb_slot_mem.sv =====
`default_nettype none
module rwb_slot_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [AW-1:0]            i_waddr,
    input  rwb_pkg::t_slot_entry    i_wdata,
    input  wire [AW-1:0]            i_raddr,
    output rwb_pkg::t_slot_entry    o_rdata
);

    rwb_pkg::t_slot_entry r_mem [DEPTH];
    rwb_pkg::t_slot_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/core/rwb_off_unit.sv =====
`default_nettype none
module rwb_off_unit (
    input  wire  [7:0] i_a,
    input  wire  [7:0] i_b,
    output logic [7:0] o_diff,
    output logic       o_borrow
);

    // modulo-256 difference, borrow set when a < b
    always_comb begin
        {o_borrow, o_diff} = {1'b0, i_a} - {1'b0, i_b};
    end

endmodule
`default_nettype wire

// ===== rtl/core/rwb_checker.sv =====
`default_nettype none
module rwb_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 start,
    input wire                 busy,
    input wire                 o_done,
    input rwb_pkg::t_rwb_out   o_rsp
);

    // a result only appears once the request is finished
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("two result beats in a row");

    a_reject_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != rwb_pkg::STS_OK) |->
            (o_rsp.slot_index == '0 && o_rsp.out_timestamp == '0))
        else $error("failed request reports slot data");

endmodule

bind reorder_window_buffer_unit rwb_checker u_rwb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
`default_nettype wire

// ===== test/testbench.sv =====
module testbench;

    localparam int WIN         = 32;
    localparam int STALL_LIMIT = 2000;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    rwb_pkg::t_rwb_in  i_req   = '0;
    logic              busy;
    logic              o_done;
    rwb_pkg::t_rwb_out o_rsp;

    // window contents as the block should hold them
    bit                   win_valid [WIN];
    rwb_pkg::t_slot_entry win_entry [WIN];
    logic [4:0]           rd_ptr     = '0;
    int unsigned          held_count = 0;

    rwb_pkg::t_rwb_out rsp_pending [$];
    int unsigned       fail_count   = 0;
    int unsigned       stall_cycles = 0;
    int unsigned       idle_pct     = 0;
    logic [7:0]        win_base     = '0;

    reorder_window_buffer_unit #(
        .WINDOW(WIN)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    function automatic rwb_pkg::t_rwb_in make_req(input rwb_pkg::t_req_type op,
                                                  input logic [7:0] seq,
                                                  input logic [9:0] len, input logic [31:0] ts,
                                                  input logic [7:0] base_sn,
                                                  input logic [7:0] next_sn);
        rwb_pkg::t_rwb_in req;
        req.req_type        = op;
        req.seqnum          = seq;
        req.seg_length      = len;
        req.timestamp       = ts;
        req.expected_seqnum = base_sn;
        req.new_expected    = next_sn;
        return req;
    endfunction

    function automatic rwb_pkg::t_rwb_out predict_window_step(input rwb_pkg::t_rwb_in req);
        rwb_pkg::t_rwb_out rsp;
        logic [7:0]        ofs;
        int                d;
        rsp = '0;
        case (rwb_pkg::t_req_type'(req.req_type))
            rwb_pkg::REQ_ADD: begin
                ofs = req.seqnum - req.expected_seqnum;
                if (ofs >= WIN) begin
                    rsp.status = rwb_pkg::STS_OUT_OF_WINDOW;
                end else if (win_valid[ofs]) begin
                    rsp.status = rwb_pkg::STS_OCCUPIED;
                end else begin
                    win_valid[ofs] = 1'b1;
                    win_entry[ofs] = '{req.seqnum, req.seg_length, req.timestamp};
                    held_count++;
                    rsp.slot_index = ofs[4:0];
                end
            end
            rwb_pkg::REQ_PEEK: begin
                rsp.status = rwb_pkg::STS_EMPTY;
                if (held_count != 0) begin
                    // forward scan only, no wrap back to slot zero
                    for (int i = rd_ptr; i < WIN; i++) begin
                        if (win_valid[i]) begin
                            rd_ptr            = 5'(i);
                            rsp.status        = rwb_pkg::STS_OK;
                            rsp.slot_index    = 5'(i);
                            rsp.out_seqnum    = win_entry[i].seqnum;
                            rsp.out_length    = win_entry[i].length;
                            rsp.out_timestamp = win_entry[i].timestamp;
                            break;
                        end
                    end
                end
            end
            rwb_pkg::REQ_POP: begin
                if (win_valid[rd_ptr]) begin
                    win_valid[rd_ptr] = 1'b0;
                    if (held_count != 0) held_count--;
                    rsp.slot_index = rd_ptr;
                end else begin
                    rsp.status = rwb_pkg::STS_EMPTY;
                end
            end
            default: begin
                ofs = req.new_expected - req.expected_seqnum;
                for (int i = 0; i < WIN; i++) begin
                    if (win_valid[i]) begin
                        win_valid[i] = 1'b0;
                        if (i >= ofs) begin
                            d            = i - ofs;
                            win_valid[d] = 1'b1;
                            win_entry[d] = win_entry[i];
                        end else if (held_count != 0) begin
                            held_count--;
                        end
                    end
                end
                rd_ptr = '0;
            end
        endcase
        rsp.is_empty_flag = (held_count == 0);
        return rsp;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    task automatic send_req(input rwb_pkg::t_rwb_in req);
        // sender holds off for single cycles, idle_pct of them on average
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy !== 1'b0);
        rsp_pending.push_back(predict_window_step(req));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (rsp_pending.size() != 0);
    endtask

    task automatic test_add_cases();
        send_req(make_req(rwb_pkg::REQ_PEEK, 8'd0, 10'd0, 32'd0, 8'd0, 8'd0));
        send_req(make_req(rwb_pkg::REQ_POP, 8'd0, 10'd0, 32'd0, 8'd0, 8'd0));
        send_req(make_req(rwb_pkg::REQ_ADD, 8'd0, 10'd0, 32'd0, 8'd0, 8'd0));
        send_req(make_req(rwb_pkg::REQ_ADD, 8'd255, 10'd512, 32'hffff_ffff, 8'd224, 8'd0));
        send_req(make_req(rwb_pkg::REQ_ADD, 8'd0, 10'd7, 32'd1, 8'd0, 8'd0));
        send_req(make_req(rwb_pkg::REQ_ADD, 8'd32, 10'd7, 32'd1, 8'd0, 8'd0));
        send_req(make_req(rwb_pkg::REQ_ADD, 8'd255, 10'd7, 32'd1, 8'd0, 8'd0));
    endtask

    task automatic test_peek_pop();
        send_req(make_req(rwb_pkg::REQ_PEEK, 8'd0, 10'd0, 32'd0, 8'd0, 8'd0));
        send_req(make_req(rwb_pkg::REQ_POP, 8'd0, 10'd0, 32'd0, 8'd0, 8'd0));
        send_req(make_req(rwb_pkg::REQ_PEEK, 8'd0, 10'd0, 32'd0, 8'd0, 8'd0));
        send_req(make_req(rwb_pkg::REQ_POP, 8'd0, 10'd0, 32'd0, 8'd0, 8'd0));
        send_req(make_req(rwb_pkg::REQ_POP, 8'd0, 10'd0, 32'd0, 8'd0, 8'd0));
        // sequence number wraps past the window base
        send_req(make_req(rwb_pkg::REQ_ADD, 8'd3, 10'd100, 32'h1234_5678, 8'd250, 8'd0));
        // pointer sits at the top slot, the stored entry lies below it
        send_req(make_req(rwb_pkg::REQ_PEEK, 8'd0, 10'd0, 32'd0, 8'd0, 8'd0));
    endtask

    task automatic test_advance();
        send_req(make_req(rwb_pkg::REQ_ADV, 8'd0, 10'd0, 32'd0, 8'd250, 8'd250));
        send_req(make_req(rwb_pkg::REQ_PEEK, 8'd0, 10'd0, 32'd0, 8'd0, 8'd0));
        send_req(make_req(rwb_pkg::REQ_ADD, 8'd14, 10'd300, 32'h8000_0001, 8'd250, 8'd0));
        send_req(make_req(rwb_pkg::REQ_ADV, 8'd0, 10'd0, 32'd0, 8'd250, 8'd0));
        send_req(make_req(rwb_pkg::REQ_PEEK, 8'd0, 10'd0, 32'd0, 8'd0, 8'd0));
        send_req(make_req(rwb_pkg::REQ_ADV, 8'd0, 10'd0, 32'd0, 8'd0, 8'd4));
        // shift of a whole window drops everything
        send_req(make_req(rwb_pkg::REQ_ADV, 8'd0, 10'd0, 32'd0, 8'd4, 8'd36));
        send_req(make_req(rwb_pkg::REQ_ADV, 8'd0, 10'd0, 32'd0, 8'd0, 8'd255));
        send_req(make_req(rwb_pkg::REQ_PEEK, 8'd0, 10'd0, 32'd0, 8'd0, 8'd0));
        win_base = 8'd0;
    endtask

    task automatic test_random_traffic(input int unsigned n_items, input int unsigned gap_pct);
        int unsigned      pick;
        int unsigned      sent;
        logic [7:0]       shift;
        rwb_pkg::t_rwb_in req;
        idle_pct = gap_pct;
        sent     = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            req  = make_req(rwb_pkg::REQ_ADD, 8'($urandom), 10'($urandom_range(0, 512)),
                            $urandom, win_base, 8'($urandom));
            if (pick < 40) begin
                if ($urandom_range(9) == 0) begin
                    req.seqnum = 8'(win_base + $urandom_range(WIN, 255));
                end else begin
                    req.seqnum = 8'(win_base + $urandom_range(0, WIN - 1));
                end
                send_req(req);
                sent++;
            end else if (pick < 65) begin
                // typical consumer: find the next segment, then release it
                req.req_type = rwb_pkg::REQ_PEEK;
                send_req(req);
                req.req_type = rwb_pkg::REQ_POP;
                send_req(req);
                sent += 2;
            end else if (pick < 73) begin
                req.req_type = rwb_pkg::REQ_PEEK;
                send_req(req);
                sent++;
            end else if (pick < 80) begin
                req.req_type = rwb_pkg::REQ_POP;
                send_req(req);
                sent++;
            end else if (pick < 95) begin
                shift = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
                req.req_type     = rwb_pkg::REQ_ADV;
                req.new_expected = win_base + shift;
                send_req(req);
                win_base = req.new_expected;
                sent++;
            end else begin
                req = make_req(rwb_pkg::t_req_type'($urandom_range(3)), 8'($urandom),
                               10'($urandom_range(0, 512)), $urandom, 8'($urandom),
                               8'($urandom));
                send_req(req);
                sent++;
            end
        end
    endtask

    always @(posedge i_clk) begin : result_check
        rwb_pkg::t_rwb_out want;
        if (i_rst_n && o_done) begin
            if (rsp_pending.size() == 0) begin
                $display("%0t: result with none expected, expected nothing, got %h",
                         $time, o_rsp);
                fail_count++;
            end else begin
                want = rsp_pending.pop_front();
                check_field("status", 32'(want.status), 32'(o_rsp.status));
                check_field("slot_index", 32'(want.slot_index), 32'(o_rsp.slot_index));
                check_field("out_seqnum", 32'(want.out_seqnum), 32'(o_rsp.out_seqnum));
                check_field("out_length", 32'(want.out_length), 32'(o_rsp.out_length));
                check_field("out_timestamp", want.out_timestamp, o_rsp.out_timestamp);
                check_field("is_empty_flag", 32'(want.is_empty_flag),
                            32'(o_rsp.is_empty_flag));
            end
        end
    end

    // counts cycles in which no beat moves on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_done === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 12;
        test_add_cases();
        test_peek_pop();
        test_advance();
        test_random_traffic(134, 12);
        test_random_traffic(134, 53);
        test_random_traffic(134, 0);
        drain_results();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
